// ===== hw/rtl/csv_four_field_line_parser_macros.svh =====
// Assertion macros shared by the line parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CSV_FOUR_FIELD_LINE_PARSER_MACROS_SVH
`define CSV_FOUR_FIELD_LINE_PARSER_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define CSVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent
`define CSVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/csvp_pkg.sv =====
// Types and constants of the CSV four-field line parser.
// Used by every module of the block; depends on nothing.
package csvp_pkg;

   // Line parsing phase
   typedef enum logic [3:0] {
      PH_LEAD  = 4'd0,
      PH_HDR_R = 4'd1,
      PH_HDR_P = 4'd2,
      PH_SKIP  = 4'd3,
      PH_ERR   = 4'd4,
      PH_PRE   = 4'd5,
      PH_NUM   = 4'd6,
      PH_POST  = 4'd7,
      PH_TAIL  = 4'd8
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_ROW  = 2'd0,
      ST_SKIP = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   localparam int unsigned ACC_W = 20;
   localparam int unsigned PROD_W = 24;
   localparam int unsigned NUM_FIELDS = 4;
   localparam logic [1:0] LAST_COL = 2'd3;

   localparam logic [ACC_W-1:0] ACC_MAX  = 20'd999999;
   localparam logic [ACC_W-1:0] WORD_MAX = 20'd65535;
   localparam logic [ACC_W-1:0] BYTE_MAX = 20'd255;

   // Character codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_UP_M    = 8'h4D;
   localparam logic [7:0] CH_UP_P    = 8'h50;
   localparam logic [7:0] CH_UP_R    = 8'h52;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   // Classification of one input byte
   typedef struct packed {
      logic       is_nul;
      logic       is_blank;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_comma;
      logic       is_comment;
      logic       is_r;
      logic       is_p;
      logic       is_m;
   } char_class_type;

   // One result item
   typedef struct packed {
      status_type  status;
      logic [15:0] rpm;
      logic [7:0]  inj_pulse;
      logic [15:0] ign_angle;
      logic [15:0] inj_end_angle;
   } result_type;

endpackage

// ===== hw/rtl/csv_four_field_line_parser.sv =====
// CSV four-field line parser, top level.
//
// Input channel req_*: one text byte per item on req_ch; a zero byte ends the
// line. Result channel rsp_*: one item per line, given at its terminator, with
// rsp_status (0 parsed row, 1 skipped line, 2 format error) and the four
// numbers rpm, inj_pulse, ign_angle and inj_end_angle, zero unless a row parsed.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// A terminator accepted into the input register is parsed there and its result
// is captured in the result register, which raises rsp_valid. Other bytes give none.
// Throughput: one byte per cycle while req_stall is low, set by the parse step
// between the input register and the result register.
// Reset clears the input and result valid flags and returns the parser to the
// start of a line. While rsp_stall holds a result, bytes that are not
// terminators keep flowing; a terminator waits in the input register and
// req_stall rises until the result register frees.
// Depends on csvp_pkg, csvp_char_class, csvp_line_fsm, csvp_out_reg.
`include "csv_four_field_line_parser_macros.svh"
module csv_four_field_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_rpm,
   output logic [7:0]  rsp_inj_pulse,
   output logic [15:0] rsp_ign_angle,
   output logic [15:0] rsp_inj_end_angle
);
   import csvp_pkg::*;

   logic           in_vld_ff, in_vld_in;
   logic [7:0]     in_ch_ff;
   char_class_type cls;
   result_type     result;
   logic           out_ready;
   logic           advance;
   logic           take;
   logic           term_step;
   logic           non_row;
   logic           fields_zero;

   csvp_char_class u_class (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   // Process the held byte unless it is a terminator facing a full result register
   assign advance   = in_vld_ff && (!cls.is_nul || out_ready);
   assign req_stall = in_vld_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign term_step = advance && cls.is_nul;

   always_comb begin
      priority if (take) in_vld_in = 1'b1;
      else if (advance)  in_vld_in = 1'b0;
      else               in_vld_in = in_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // Hold the accepted byte
   always_ff @(posedge clock) begin
      if (take) begin
         in_ch_ff <= req_ch;
      end
   end

   csvp_line_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cls    (cls),
      .result (result)
   );

   csvp_out_reg u_out (
      .clock             (clock),
      .reset             (reset),
      .load              (term_step),
      .result            (result),
      .ready             (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_rpm           (rsp_rpm),
      .rsp_inj_pulse     (rsp_inj_pulse),
      .rsp_ign_angle     (rsp_ign_angle),
      .rsp_inj_end_angle (rsp_inj_end_angle)
   );

   assign non_row     = rsp_valid && (rsp_status != ST_ROW);
   assign fields_zero = (rsp_rpm == 16'd0) && (rsp_inj_pulse == 8'd0) &&
                        (rsp_ign_angle == 16'd0) && (rsp_inj_end_angle == 16'd0);

   `CSVP_ASSERT_NEXT(a_term_gives_result, clock, reset, term_step, rsp_valid, "result lost")
   `CSVP_ASSERT_NOW(a_zero_unless_row, clock, reset, non_row, fields_zero, "fields on non-row")

endmodule

// ===== hw/rtl/csvp_char_class.sv =====
// Byte classifier of the line parser: blanks, digits, separators, header letters.
// Depends on csvp_pkg.
module csvp_char_class (
   input  logic [7:0]               ch,
   output csvp_pkg::char_class_type cls
);
   import csvp_pkg::*;

   logic [7:0] upper;

   // Fold lower-case letters to upper case
   always_comb begin
      if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
         upper = ch - CASE_GAP;
      end else begin
         upper = ch;
      end
   end

   // Classify the byte
   always_comb begin
      cls.is_nul     = (ch == CH_NUL);
      cls.is_blank   = (ch == CH_SPACE) || (ch == CH_TAB);
      cls.is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
      cls.digit      = 4'(ch - CH_ZERO);
      cls.is_comma   = (ch == CH_COMMA);
      cls.is_comment = (ch == CH_HASH) || (ch == CH_SEMI);
      cls.is_r       = (upper == CH_UP_R);
      cls.is_p       = (upper == CH_UP_P);
      cls.is_m       = (upper == CH_UP_M);
   end

endmodule

// ===== hw/rtl/csvp_line_fsm.sv =====
// Line parsing state machine: phase, column, decimal accumulator and field store.
// Depends on csvp_pkg and the assertion macro header.
`include "csv_four_field_line_parser_macros.svh"
module csvp_line_fsm (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  csvp_pkg::char_class_type cls,
   output csvp_pkg::result_type     result
);
   import csvp_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [1:0]       col_ff, col_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] field_ff [NUM_FIELDS];

   logic [PROD_W-1:0] prod;
   logic              ovf;
   logic              fld_we;
   logic [1:0]        fld_idx;
   logic [ACC_W-1:0]  fld_val;
   logic              in_row;
   logic              in_limits;
   logic              at_line_start;

   // Multiply by ten and add the new digit
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {20'd0, cls.digit};
   assign ovf  = (prod > PROD_W'(ACC_MAX));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (cls.is_nul) begin
         phase_in = PH_LEAD;
      end else begin
         unique case (phase_ff)
            PH_LEAD: begin
               priority if (cls.is_blank) phase_in = PH_LEAD;
               else if (cls.is_comment)   phase_in = PH_SKIP;
               else if (cls.is_r)         phase_in = PH_HDR_R;
               else if (cls.is_digit)     phase_in = PH_NUM;
               else                       phase_in = PH_ERR;
            end
            PH_HDR_R: phase_in = cls.is_p ? PH_HDR_P : PH_ERR;
            PH_HDR_P: phase_in = cls.is_m ? PH_SKIP : PH_ERR;
            PH_SKIP:  phase_in = PH_SKIP;
            PH_ERR:   phase_in = PH_ERR;
            PH_PRE: begin
               priority if (cls.is_blank) phase_in = PH_PRE;
               else if (cls.is_digit)     phase_in = PH_NUM;
               else                       phase_in = PH_ERR;
            end
            PH_NUM: begin
               priority if (cls.is_digit) phase_in = ovf ? PH_ERR : PH_NUM;
               else if (col_ff == LAST_COL)
                  phase_in = (cls.is_blank || cls.is_comma) ? PH_TAIL : PH_ERR;
               else if (cls.is_blank)     phase_in = PH_POST;
               else if (cls.is_comma)     phase_in = PH_PRE;
               else                       phase_in = PH_ERR;
            end
            PH_POST: begin
               priority if (cls.is_blank) phase_in = PH_POST;
               else if (col_ff == LAST_COL)
                  phase_in = cls.is_comma ? PH_TAIL : PH_ERR;
               else if (cls.is_comma)     phase_in = PH_PRE;
               else                       phase_in = PH_ERR;
            end
            PH_TAIL: phase_in = (cls.is_blank || cls.is_comma) ? PH_TAIL : PH_ERR;
            default: phase_in = PH_ERR;
         endcase
      end
   end

   // Column, accumulator and field store updates
   always_comb begin
      col_in  = col_ff;
      acc_in  = acc_ff;
      fld_we  = 1'b0;
      fld_idx = col_ff;
      fld_val = prod[ACC_W-1:0];
      if (cls.is_nul) begin
         col_in = 2'd0;
         acc_in = '0;
      end else begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (!cls.is_blank && !cls.is_comment && !cls.is_r && cls.is_digit) begin
                  col_in  = 2'd0;
                  acc_in  = ACC_W'(cls.digit);
                  fld_we  = 1'b1;
                  fld_idx = 2'd0;
                  fld_val = ACC_W'(cls.digit);
               end
            end
            PH_PRE: begin
               if (!cls.is_blank && cls.is_digit) begin
                  acc_in  = ACC_W'(cls.digit);
                  fld_we  = 1'b1;
                  fld_val = ACC_W'(cls.digit);
               end
            end
            PH_NUM: begin
               priority if (cls.is_digit) begin
                  if (!ovf) begin
                     acc_in = prod[ACC_W-1:0];
                     fld_we = 1'b1;
                  end
               end else if (col_ff != LAST_COL && !cls.is_blank && cls.is_comma) begin
                  col_in = col_ff + 2'd1;
                  acc_in = '0;
               end else begin
                  acc_in = acc_ff;
               end
            end
            PH_POST: begin
               if (!cls.is_blank && col_ff != LAST_COL && cls.is_comma) begin
                  col_in = col_ff + 2'd1;
                  acc_in = '0;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   // Result at the terminator
   assign in_row = (col_ff == LAST_COL) &&
                   (phase_ff == PH_NUM || phase_ff == PH_POST || phase_ff == PH_TAIL);
   assign in_limits = (field_ff[0] <= WORD_MAX) && (field_ff[1] <= BYTE_MAX) &&
                      (field_ff[2] <= WORD_MAX) && (field_ff[3] <= WORD_MAX);

   always_comb begin
      result = '0;
      priority if (phase_ff == PH_LEAD || phase_ff == PH_SKIP) begin
         result.status = ST_SKIP;
      end else if (in_row && in_limits) begin
         result.status        = ST_ROW;
         result.rpm           = field_ff[0][15:0];
         result.inj_pulse     = field_ff[1][7:0];
         result.ign_angle     = field_ff[2][15:0];
         result.inj_end_angle = field_ff[3][15:0];
      end else begin
         result.status = ST_ERR;
      end
   end

   // Advance the parse state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         col_ff   <= 2'd0;
         acc_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         acc_ff   <= acc_in;
      end
   end

   // Hold the field values; written only as digits arrive
   always_ff @(posedge clock) begin
      if (step && fld_we) begin
         field_ff[fld_idx] <= fld_val;
      end
   end

   assign at_line_start = (phase_ff == PH_LEAD) && (col_ff == 2'd0) && (acc_ff == '0);

   `CSVP_ASSERT_NOW(a_acc_bound, clock, reset, 1'b1, acc_ff <= ACC_MAX, "accumulator above limit")
   `CSVP_ASSERT_NEXT(a_line_restart, clock, reset, step && cls.is_nul, at_line_start, "no restart")

endmodule

// ===== hw/rtl/csvp_out_reg.sv =====
// Result register of the line parser, with valid and stall handshake.
// Depends on csvp_pkg.
module csvp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  csvp_pkg::result_type result,
   output logic                 ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_rpm,
   output logic [7:0]           rsp_inj_pulse,
   output logic [15:0]          rsp_ign_angle,
   output logic [15:0]          rsp_inj_end_angle
);
   import csvp_pkg::*;

   logic       vld_ff, vld_in;
   result_type res_ff;

   // Free when empty or when the held item leaves this cycle
   assign ready = !vld_ff || !rsp_stall;

   always_comb begin
      priority if (load) vld_in = 1'b1;
      else if (ready)    vld_in = 1'b0;
      else               vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Capture the result item
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_status        = res_ff.status;
   assign rsp_rpm           = res_ff.rpm;
   assign rsp_inj_pulse     = res_ff.inj_pulse;
   assign rsp_ign_angle     = res_ff.ign_angle;
   assign rsp_inj_end_angle = res_ff.inj_end_angle;

endmodule

// ===== tb/sv/csv_four_field_line_parser_test.sv =====
// Self-checking testbench of the CSV four-field line parser.
// Needs csvp_pkg and the csv_four_field_line_parser RTL; reads nothing else.
`timescale 1ns / 1ps
module csv_four_field_line_parser_test;
   import csvp_pkg::*;

   // One directed line: its text and, where obvious, its expected result
   typedef struct {
      string      text;
      bit         typed;
      result_type res;
   } line_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_rpm;
   logic [7:0]  rsp_inj_pulse;
   logic [15:0] rsp_ign_angle;
   logic [15:0] rsp_inj_end_angle;

   // Line parser mirror
   phase_type   ln_phase = PH_LEAD;
   logic [1:0]  ln_col = 2'd0;
   logic [19:0] ln_acc = 20'd0;
   logic [19:0] ln_field [NUM_FIELDS];

   result_type    pending_rows [$];
   logic [7:0]    line_buf [$];
   line_case_type cases [$];
   bit            typed_active = 1'b0;
   result_type    typed_result;
   bit            calm = 1'b0;
   int unsigned   mismatches = 0;
   int unsigned   sink_hold = 0;

   csv_four_field_line_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_rpm           (rsp_rpm),
      .rsp_inj_pulse     (rsp_inj_pulse),
      .rsp_ign_angle     (rsp_ign_angle),
      .rsp_inj_end_angle (rsp_inj_end_angle)
   );

   always #2 clock = ~clock;

   // Start a number in the current column
   function automatic void open_number(input logic [7:0] c);
      ln_acc = 20'(c - CH_ZERO);
      ln_field[ln_col] = ln_acc;
      ln_phase = PH_NUM;
   endfunction

   // Advance to the next column after a comma
   function automatic void next_field();
      ln_col = ln_col + 2'd1;
      ln_acc = 20'd0;
      ln_phase = PH_PRE;
   endfunction

   // Advance the parser mirror by one byte; return 1 with the line result
   // when the byte is a terminator
   function automatic bit parse_byte(input logic [7:0] c, output result_type res);
      logic [7:0]  up;
      logic        blank;
      logic        digit;
      logic        comma;
      logic [23:0] grown;
      status_type  st;
      up = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
      blank = (c == CH_SPACE) || (c == CH_TAB);
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      comma = (c == CH_COMMA);
      res = '0;
      if (c == CH_NUL) begin
         if (ln_phase == PH_LEAD || ln_phase == PH_SKIP) begin
            st = ST_SKIP;
         end else if (ln_col == LAST_COL &&
                      (ln_phase == PH_NUM || ln_phase == PH_POST || ln_phase == PH_TAIL)) begin
            st = (ln_field[0] > WORD_MAX || ln_field[1] > BYTE_MAX ||
                  ln_field[2] > WORD_MAX || ln_field[3] > WORD_MAX) ? ST_ERR : ST_ROW;
         end else begin
            st = ST_ERR;
         end
         res.status = st;
         if (st == ST_ROW) begin
            res.rpm = ln_field[0][15:0];
            res.inj_pulse = ln_field[1][7:0];
            res.ign_angle = ln_field[2][15:0];
            res.inj_end_angle = ln_field[3][15:0];
         end
         ln_phase = PH_LEAD;
         ln_col = 2'd0;
         ln_acc = 20'd0;
         return 1'b1;
      end
      case (ln_phase)
         PH_LEAD: begin
            if (!blank) begin
               if (c == CH_HASH || c == CH_SEMI) ln_phase = PH_SKIP;
               else if (up == CH_UP_R) ln_phase = PH_HDR_R;
               else if (digit) begin
                  ln_col = 2'd0;
                  open_number(c);
               end else ln_phase = PH_ERR;
            end
         end
         PH_HDR_R: ln_phase = (up == CH_UP_P) ? PH_HDR_P : PH_ERR;
         PH_HDR_P: ln_phase = (up == CH_UP_M) ? PH_SKIP : PH_ERR;
         PH_SKIP, PH_ERR: ;
         PH_PRE: begin
            if (!blank) begin
               if (digit) open_number(c);
               else ln_phase = PH_ERR;
            end
         end
         PH_NUM: begin
            if (digit) begin
               grown = 24'(ln_acc) * 24'd10 + 24'(c - CH_ZERO);
               if (grown > 24'(ACC_MAX)) ln_phase = PH_ERR;
               else begin
                  ln_acc = grown[19:0];
                  ln_field[ln_col] = ln_acc;
               end
            end else if (ln_col == LAST_COL) ln_phase = (blank || comma) ? PH_TAIL : PH_ERR;
            else if (blank) ln_phase = PH_POST;
            else if (comma) next_field();
            else ln_phase = PH_ERR;
         end
         PH_POST: begin
            if (!blank) begin
               if (ln_col == LAST_COL) ln_phase = comma ? PH_TAIL : PH_ERR;
               else if (comma) next_field();
               else ln_phase = PH_ERR;
            end
         end
         PH_TAIL: if (!blank && !comma) ln_phase = PH_ERR;
         default: ln_phase = PH_ERR;
      endcase
      return 1'b0;
   endfunction

   function automatic result_type mk_result(input status_type st, input int unsigned a,
                                            input int unsigned b, input int unsigned g,
                                            input int unsigned e);
      result_type r;
      r.status = st;
      r.rpm = 16'(a);
      r.inj_pulse = 8'(b);
      r.ign_angle = 16'(g);
      r.inj_end_angle = 16'(e);
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 8);
      return $urandom_range(12, 40);
   endfunction

   // Offer one byte, wait for it to be taken, then record what it predicts
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      result_type  res;
      gap = calm ? 0 : idle_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_ch <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (parse_byte(b, res))
         pending_rows.push_back(typed_active ? typed_result : res);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      send_byte(CH_NUL);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic append_blanks();
      int unsigned n;
      n = ($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 3);
      repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   // Mostly in range, with limits, just past them and accumulator overflow
   task automatic append_number(input int unsigned lim);
      int unsigned r;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 60) v = $urandom_range(0, lim);
      else if (r < 80) v = $urandom_range(0, 99);
      else if (r < 85) v = lim;
      else if (r < 88) v = lim + 1;
      else if (r < 92) v = $urandom_range(lim + 1, 999999);
      else if (r < 94) v = $urandom_range(999999, 1000000);
      else if (r < 96) v = $urandom_range(1000001, 9999999);
      else v = 0;
      if ($urandom_range(0, 9) == 0) append_text($urandom_range(0, 1) ? "0" : "00");
      append_text($sformatf("%0d", v));
   endtask

   task automatic build_random_line();
      int unsigned kind;
      int unsigned n;
      int unsigned cut;
      line_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         // Well-formed row, sometimes broken by one byte or cut short
         append_blanks();
         for (int f = 0; f < NUM_FIELDS; f++) begin
            append_blanks();
            append_number(f == 1 ? 255 : 65535);
            append_blanks();
            if (f < NUM_FIELDS - 1) line_buf.push_back(CH_COMMA);
         end
         n = $urandom_range(0, 3);
         repeat (n) line_buf.push_back($urandom_range(0, 2) == 0 ? CH_COMMA : CH_SPACE);
         n = $urandom_range(0, 9);
         if (n == 0) begin
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(1, 255));
         end else if (n == 1) begin
            cut = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > cut) void'(line_buf.pop_back());
         end
      end else if (kind < 70) begin
         // Comment or header with arbitrary trailing bytes
         append_blanks();
         n = $urandom_range(0, 2);
         if (n == 0) line_buf.push_back(CH_HASH);
         else if (n == 1) line_buf.push_back(CH_SEMI);
         else begin
            line_buf.push_back(CH_UP_R + ($urandom_range(0, 1) ? CASE_GAP : 8'h00));
            line_buf.push_back(CH_UP_P + ($urandom_range(0, 1) ? CASE_GAP : 8'h00));
            line_buf.push_back(CH_UP_M + ($urandom_range(0, 1) ? CASE_GAP : 8'h00));
         end
         repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 78) begin
         // Header that breaks off
         line_buf.push_back(CH_UP_R + ($urandom_range(0, 1) ? CASE_GAP : 8'h00));
         if ($urandom_range(0, 1)) line_buf.push_back(CH_UP_P);
         if ($urandom_range(0, 1)) line_buf.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 85) begin
         append_blanks();
      end else begin
         repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(1, 255)));
      end
   endtask

   // Keep the result side stalling in runs of random length
   always @(negedge clock) begin
      if (sink_hold != 0) begin
         rsp_stall <= 1'b1;
         sink_hold = sink_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 99) < 30) sink_hold = idle_len();
      end
   end

   // Compare each taken result with the oldest expectation
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.status = status_type'(rsp_status);
         got.rpm = rsp_rpm;
         got.inj_pulse = rsp_inj_pulse;
         got.ign_angle = rsp_ign_angle;
         got.inj_end_angle = rsp_inj_end_angle;
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: result with none expected, status %0d", $realtime,
                        rsp_status);
         end else begin
            want = pending_rows.pop_front();
            if (got.status !== want.status || got.rpm !== want.rpm ||
                got.inj_pulse !== want.inj_pulse || got.ign_angle !== want.ign_angle ||
                got.inj_end_angle !== want.inj_end_angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR %0t: expected %0d %0d %0d %0d %0d,", $realtime,
                           want.status, want.rpm, want.inj_pulse, want.ign_angle,
                           want.inj_end_angle, " got %0d %0d %0d %0d %0d", rsp_status,
                           rsp_rpm, rsp_inj_pulse, rsp_ign_angle, rsp_inj_end_angle);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned sent_lines;
      int unsigned random_bytes;
      int unsigned k;
      for (int f = 0; f < NUM_FIELDS; f++) ln_field[f] = 20'd0;

      // Directed lines: empty, blanks, comments, headers, limits, errors
      cases.push_back('{"", 1'b1, mk_result(ST_SKIP, 0, 0, 0, 0)});
      cases.push_back('{"   \t", 1'b1, mk_result(ST_SKIP, 0, 0, 0, 0)});
      cases.push_back('{"# 1,2,3,4", 1'b1, mk_result(ST_SKIP, 0, 0, 0, 0)});
      cases.push_back('{" \t;x", 1'b1, mk_result(ST_SKIP, 0, 0, 0, 0)});
      cases.push_back('{"rPm,ms,deg", 1'b1, mk_result(ST_SKIP, 0, 0, 0, 0)});
      cases.push_back('{"R", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"rp", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"RX", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"0,0,0,0", 1'b1, mk_result(ST_ROW, 0, 0, 0, 0)});
      cases.push_back('{"65535,255,65535,65535", 1'b1,
                        mk_result(ST_ROW, 65535, 255, 65535, 65535)});
      cases.push_back('{"65536,0,0,0", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"0,256,0,0", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"0,0,65536,0", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"0,0,0,999999", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"1000000,1,2,3", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"1,2,3", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"1,2,3,4,5", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"1,2,,3,4", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"1 2,3,4,5", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"1,2,3,4x", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{"a", 1'b1, mk_result(ST_ERR, 0, 0, 0, 0)});
      cases.push_back('{" 1 ,\t2, 3 ,4 , ,\t", 1'b0, '0});
      cases.push_back('{"007,08,9,0010", 1'b0, '0});
      cases.push_back('{"12,34,56,78\t", 1'b0, '0});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (cases[i]) begin
         line_buf.delete();
         append_text(cases[i].text);
         typed_active = cases[i].typed;
         typed_result = cases[i].res;
         send_line();
      end
      typed_active = 1'b0;

      // Hold the input until the directed results have all drained
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);

      // Random lines, mostly well-formed rows
      sent_lines = 0;
      random_bytes = 0;
      while (random_bytes < 1800) begin
         calm = ($urandom_range(0, 7) == 0);
         build_random_line();
         random_bytes += line_buf.size() + 1;
         send_line();
         sent_lines++;
         if (sent_lines == 40) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_rows.size() != 0) @(posedge clock);
         end
      end
      calm = 1'b0;

      // Drain, then allow for the pipeline latency
      @(negedge clock);
      req_valid <= 1'b0;
      for (k = 0; k < 4000 && pending_rows.size() != 0; k++) @(posedge clock);
      if (pending_rows.size() != 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR %0t: %0d results never arrived", $realtime, pending_rows.size());
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #10000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
